FILE: rtl/sfcr_pkg.sv
// Package for the sensor frame check and retry block: result codes, register
// indexes, conversion constants and the CRC-8 byte update.
// No dependencies.
package sfcr_pkg;

    // Outcome codes
    typedef enum logic [1:0] {
        OUT_SUCCESS = 2'd0,
        OUT_RETRY   = 2'd1,
        OUT_GAVE_UP = 2'd2
    } outcome_t;

    // Error kinds
    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_BUS  = 2'd1,
        ERR_CRC  = 2'd2
    } error_kind_t;

    // Register indexes (word address = paddr[3:2])
    typedef enum logic [1:0] {
        REG_MAX_ATTEMPTS       = 2'd0,
        REG_BASE_BACKOFF_MS    = 2'd1,
        REG_RESET_FROM_ATTEMPT = 2'd2,
        REG_UNUSED             = 2'd3
    } reg_index_t;

    // Register reset values
    localparam logic [3:0] MAX_ATTEMPTS_RST       = 4'd5;
    localparam logic [7:0] BASE_BACKOFF_RST       = 8'd10;
    localparam logic [2:0] RESET_FROM_ATTEMPT_RST = 3'd2;

    // Attempt limits after clamping
    localparam logic [3:0] ATTEMPTS_MIN = 4'd1;
    localparam logic [3:0] ATTEMPTS_MAX = 4'd8;

    // CRC-8 polynomial x^8+x^5+x^4+1, MSB first
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Conversion: value = floor(SCALE * raw / 65536) + OFFSET
    localparam logic [14:0] TEMP_SCALE   = 15'd17572;
    localparam logic [14:0] HUMID_SCALE  = 15'd12500;
    localparam logic signed [15:0] TEMP_OFFSET  = -16'sd4685;
    localparam logic signed [15:0] HUMID_OFFSET = -16'sd600;
    localparam logic signed [15:0] HUMID_CEIL   = 16'sd10000;

    // Status bits in the low data byte
    localparam logic [15:0] STATUS_MASK = 16'hFFFC;

    // Shift one byte through the CRC register, eight steps
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/sensor_frame_check_retry_top.sv
// Top level of the sensor frame check and retry block: CRC check, value
// conversion, retry bookkeeping and the APB register bank.
// Depends on sfcr_pkg.
//
// An accepted input word gives a valid result word in the next cycle.
// Throughput: one word per cycle; the single result register is refilled in
// the same cycle it is drained, so input ready follows the result side.
// Reset: synchronous, active low; clears the attempt index, result valid and
// restores register defaults (max_attempts 5, base_backoff_ms 10,
// reset_from_attempt 2).
module sensor_frame_check_retry_top (
    input  logic        aclk,
    input  logic        aresetn,

    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_bus_ok,
    input  logic        s_measure_kind,
    input  logic [7:0]  s_data_high,
    input  logic [7:0]  s_data_low,
    input  logic [7:0]  s_check_byte,

    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_outcome,
    output logic [1:0]  m_error_kind,
    output logic        m_soft_reset,
    output logic [14:0] m_backoff_ms,
    output logic signed [14:0] m_value,
    output logic [3:0]  m_attempt_number
);
    import sfcr_pkg::*;

    // Configuration registers
    logic [3:0]  max_attempts_reg;
    logic [7:0]  base_backoff_reg;
    logic [2:0]  reset_from_reg;

    // Attempt state and result register
    logic [2:0]  attempt_index_reg, attempt_index_next;
    logic        m_valid_reg;
    outcome_t    outcome_reg, outcome_next;
    error_kind_t error_kind_reg, error_kind_next;
    logic        soft_reset_reg, soft_reset_next;
    logic [14:0] backoff_reg, backoff_next;
    logic signed [14:0] value_reg, value_next;
    logic [3:0]  attempt_number_reg, attempt_number_next;

    logic        cfg_write;
    reg_index_t  cfg_index;
    logic        in_accept;

    // Datapath intermediates
    logic [7:0]  crc_calc;
    logic [15:0] raw;
    logic [14:0] scale;
    logic [30:0] product;
    logic signed [15:0] conv;
    logic [3:0]  max_eff;
    logic [3:0]  attempt_plus1;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    // Read back the addressed register
    always_comb begin
        unique case (cfg_index)
            REG_MAX_ATTEMPTS:       prdata = {28'd0, max_attempts_reg};
            REG_BASE_BACKOFF_MS:    prdata = {24'd0, base_backoff_reg};
            REG_RESET_FROM_ATTEMPT: prdata = {29'd0, reset_from_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // Write the addressed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_attempts_reg <= MAX_ATTEMPTS_RST;
            base_backoff_reg <= BASE_BACKOFF_RST;
            reset_from_reg   <= RESET_FROM_ATTEMPT_RST;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_MAX_ATTEMPTS:       max_attempts_reg <= pwdata[3:0];
                REG_BASE_BACKOFF_MS:    base_backoff_reg <= pwdata[7:0];
                REG_RESET_FROM_ATTEMPT: reset_from_reg   <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Take a new word whenever the result register is empty or draining
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    // Check the frame CRC over high then low byte
    assign crc_calc = crc8_byte(crc8_byte(8'h00, s_data_high), s_data_low);

    // Convert the raw reading with one shared constant multiply
    assign raw     = {s_data_high, s_data_low} & STATUS_MASK;
    assign scale   = s_measure_kind ? TEMP_SCALE : HUMID_SCALE;
    assign product = 31'(scale) * 31'(raw);

    always_comb begin
        logic signed [15:0] scaled;
        scaled = $signed({1'b0, product[30:16]});
        if (s_measure_kind) begin
            conv = scaled + TEMP_OFFSET;
        end else begin
            conv = scaled + HUMID_OFFSET;
            if (conv < 16'sd0) begin
                conv = 16'sd0;
            end else if (conv > HUMID_CEIL) begin
                conv = HUMID_CEIL;
            end
        end
    end

    // Clamp the attempt limit into 1..8
    always_comb begin
        if (max_attempts_reg < ATTEMPTS_MIN) begin
            max_eff = ATTEMPTS_MIN;
        end else if (max_attempts_reg > ATTEMPTS_MAX) begin
            max_eff = ATTEMPTS_MAX;
        end else begin
            max_eff = max_attempts_reg;
        end
    end

    assign attempt_plus1 = {1'b0, attempt_index_reg} + 4'd1;

    // Decide the outcome and the next attempt index
    always_comb begin
        attempt_number_next = attempt_plus1;
        if (!s_bus_ok) begin
            error_kind_next = ERR_BUS;
        end else if (crc_calc != s_check_byte) begin
            error_kind_next = ERR_CRC;
        end else begin
            error_kind_next = ERR_NONE;
        end

        if (error_kind_next == ERR_NONE) begin
            outcome_next       = OUT_SUCCESS;
            soft_reset_next    = 1'b0;
            backoff_next       = 15'd0;
            value_next         = conv[14:0];
            attempt_index_next = 3'd0;
        end else begin
            soft_reset_next = (attempt_index_reg >= reset_from_reg);
            backoff_next    = 15'({7'd0, base_backoff_reg} << attempt_index_reg);
            value_next      = 15'sd0;
            if (attempt_plus1 >= max_eff) begin
                outcome_next       = OUT_GAVE_UP;
                attempt_index_next = 3'd0;
            end else begin
                outcome_next       = OUT_RETRY;
                attempt_index_next = attempt_plus1[2:0];
            end
        end
    end

    // Advance state and hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg       <= 1'b0;
            attempt_index_reg <= 3'd0;
        end else begin
            if (in_accept) begin
                m_valid_reg       <= 1'b1;
                attempt_index_reg <= attempt_index_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            outcome_reg        <= outcome_next;
            error_kind_reg     <= error_kind_next;
            soft_reset_reg     <= soft_reset_next;
            backoff_reg        <= backoff_next;
            value_reg          <= value_next;
            attempt_number_reg <= attempt_number_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_outcome        = outcome_reg;
    assign m_error_kind     = error_kind_reg;
    assign m_soft_reset     = soft_reset_reg;
    assign m_backoff_ms     = backoff_reg;
    assign m_value          = value_reg;
    assign m_attempt_number = attempt_number_reg;

endmodule
